// File: hdl/i2cmts_pkg.sv
`default_nettype none
package i2cmts_pkg;

  // Number of request slots in the queue.
  localparam int unsigned QUEUE_SLOTS = 3;
  localparam int unsigned SLOT_W      = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  // Address byte masks for the R/W bit.
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PROBE = 2'd2,
    OP_EVENT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_START     = 4'd1,
    ACT_SEND_ADDR = 4'd2,
    ACT_SEND_CMD  = 4'd3,
    ACT_SEND_DATA = 4'd4,
    ACT_RECEIVE   = 4'd5,
    ACT_ACK       = 4'd6,
    ACT_NACK      = 4'd7,
    ACT_STOP      = 4'd8,
    ACT_RESTART   = 4'd9
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SEND_ADDR  = 4'd1,
    PH_CMD_DATA   = 4'd2,
    PH_WR_DATA    = 4'd3,
    PH_WR_STOP    = 4'd4,
    PH_DONE       = 4'd5,
    PH_RD_START   = 4'd6,
    PH_RD_ADDR    = 4'd7,
    PH_RD_ENABLE  = 4'd8,
    PH_RD_REENABLE = 4'd9,
    PH_RD_STORE   = 4'd10,
    PH_RD_STOP    = 4'd11
  } phase_e;

  // One input item.
  typedef struct packed {
    logic [1:0]  op;
    logic        bus_normal;
    logic [7:0]  device_address;
    logic [7:0]  command_length;
    logic [15:0] payload_length;
    logic [7:0]  request_tag;
    logic        nack;
    logic [7:0]  received_byte;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  send_byte;
    logic [15:0] buffer_index;
    logic        store_byte;
    logic [7:0]  stored_value;
    logic        accepted;
    logic        done_res;
    logic        success;
    logic [7:0]  done_tag;
  } rsp_t;

  // Queued request fields (the pending flag is kept apart).
  typedef struct packed {
    logic        is_read;
    logic [7:0]  address;
    logic [7:0]  cmd_len;
    logic [15:0] size;
    logic [7:0]  tag;
  } slot_t;

  // Fields of the transaction on the bus.
  typedef struct packed {
    logic [7:0]  address;
    logic [7:0]  cmd_len;
    logic [15:0] wr_len;
    logic [15:0] rd_len;
    logic [7:0]  tag;
  } active_t;

endpackage
`default_nettype wire

// File: hdl/i2cmts_if.sv
`default_nettype none
// Channel that carries input items.
interface i2cmts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        bus_normal;
  logic [7:0]  device_address;
  logic [7:0]  command_length;
  logic [15:0] payload_length;
  logic [7:0]  request_tag;
  logic        nack;
  logic [7:0]  received_byte;

  modport source (
    output valid, op, bus_normal, device_address, command_length, payload_length,
    output request_tag, nack, received_byte,
    input  ready
  );
  modport sink (
    input  valid, op, bus_normal, device_address, command_length, payload_length,
    input  request_tag, nack, received_byte,
    output ready
  );
endinterface

// Channel that carries result items.
interface i2cmts_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [7:0]  send_byte;
  logic [15:0] buffer_index;
  logic        store_byte;
  logic [7:0]  stored_value;
  logic        accepted;
  logic        done_res;
  logic        success;
  logic [7:0]  done_tag;

  modport source (
    output valid, action, send_byte, buffer_index, store_byte, stored_value,
    output accepted, done_res, success, done_tag,
    input  ready
  );
  modport sink (
    input  valid, action, send_byte, buffer_index, store_byte, stored_value,
    input  accepted, done_res, success, done_tag,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/i2c_master_transaction_sequencer_unit.sv
`default_nettype none
// Pipeline: an accepted input item is held in the input register; its result item is
// computed combinationally from it and loaded into the result register.
// One item per cycle while the result register is empty or taken (rsp_o.ready high);
// a full result register that is not taken stalls the input register.
// Reset (rst_ni low, asynchronous): phase idle, not busy, queue empty, both
// pipeline registers empty.
module i2c_master_transaction_sequencer_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  i2cmts_req_if.sink  req_i,
  i2cmts_rsp_if.source rsp_o
);
  import i2cmts_pkg::*;

  // Pipeline registers.
  logic    in_vq;
  req_t    in_q;
  logic    out_vq;
  rsp_t    out_q;
  logic    adv;
  logic    proc;

  // Sequencer state.
  phase_e  phase_q, phase_d;
  logic    busy_q, busy_d;
  logic [15:0] idx_q, idx_d;
  active_t act_q, act_d;
  logic [QUEUE_SLOTS-1:0] pend_q, pend_d;
  slot_t   slot_q [QUEUE_SLOTS];
  rsp_t    rsp_d;

  // Queue scan signals.
  logic    is_req;
  logic    free_found;
  logic [SLOT_W-1:0] free_sel;
  logic [QUEUE_SLOTS-1:0] pend_w;
  logic    serve_found;
  logic [SLOT_W-1:0] serve_sel;
  logic    do_serve;
  logic    wr_slot;
  logic [15:0] idx_inc;
  slot_t   new_slot;

  // Handshakes: the input stage advances whenever the result register can take a value.
  assign adv         = !out_vq || rsp_o.ready;
  assign proc        = in_vq && adv;
  assign req_i.ready = !in_vq || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_vq <= 1'b1;
    end else if (proc) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.op             <= req_i.op;
      in_q.bus_normal     <= req_i.bus_normal;
      in_q.device_address <= req_i.device_address;
      in_q.command_length <= req_i.command_length;
      in_q.payload_length <= req_i.payload_length;
      in_q.request_tag    <= req_i.request_tag;
      in_q.nack           <= req_i.nack;
      in_q.received_byte  <= req_i.received_byte;
    end
  end

  // Queue scan: lowest free slot, and lowest pending slot after the write.
  assign is_req = (in_q.op == OP_WRITE) || (in_q.op == OP_READ);

  always_comb begin
    free_found  = 1'b0;
    free_sel    = '0;
    pend_w      = pend_q;
    serve_found = 1'b0;
    serve_sel   = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!pend_q[i]) begin
        free_found = 1'b1;
        free_sel   = SLOT_W'(i);
      end
    end
    if (is_req && free_found) begin
      pend_w[free_sel] = 1'b1;
    end
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (pend_w[i]) begin
        serve_found = 1'b1;
        serve_sel   = SLOT_W'(i);
      end
    end
  end

  assign new_slot.is_read = (in_q.op == OP_READ);
  assign new_slot.address = in_q.device_address;
  assign new_slot.cmd_len = in_q.command_length;
  assign new_slot.size    = in_q.payload_length;
  assign new_slot.tag     = in_q.request_tag;
  assign idx_inc          = idx_q + 16'd1;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d  = phase_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    act_d    = act_q;
    pend_d   = pend_q;
    rsp_d    = '0;
    do_serve = 1'b0;
    wr_slot  = 1'b0;

    case (op_e'(in_q.op))
      OP_WRITE, OP_READ: begin
        if (!free_found) begin
          pend_d  = '0;
          phase_d = PH_IDLE;
          busy_d  = 1'b0;
        end else begin
          wr_slot = 1'b1;
          pend_d  = pend_w;
          if (serve_found && in_q.bus_normal && !busy_q) begin
            do_serve       = 1'b1;
            rsp_d.accepted = 1'b1;
          end
        end
      end
      OP_PROBE: begin
        if (in_q.bus_normal && !busy_q) begin
          act_d.address  = in_q.device_address;
          act_d.cmd_len  = '0;
          act_d.wr_len   = '0;
          act_d.rd_len   = '0;
          act_d.tag      = in_q.request_tag;
          busy_d         = 1'b1;
          idx_d          = '0;
          phase_d        = PH_SEND_ADDR;
          rsp_d.action   = ACT_START;
          rsp_d.accepted = 1'b1;
        end
      end
      default: begin
        case (phase_q)
          PH_SEND_ADDR: begin
            rsp_d.action    = ACT_SEND_ADDR;
            rsp_d.send_byte = act_q.address & ADDR_WR_MASK;
            phase_d         = PH_CMD_DATA;
          end
          PH_CMD_DATA: begin
            if (in_q.nack) begin
              phase_d        = PH_IDLE;
              busy_d         = 1'b0;
              rsp_d.action   = ACT_STOP;
              rsp_d.done_res = 1'b1;
              rsp_d.done_tag = act_q.tag;
            end else if (act_q.cmd_len == 8'd0) begin
              rsp_d.action = ACT_STOP;
              phase_d      = PH_DONE;
            end else begin
              rsp_d.action       = ACT_SEND_CMD;
              rsp_d.buffer_index = idx_q;
              idx_d              = idx_inc;
              if (idx_inc >= {8'd0, act_q.cmd_len}) begin
                idx_d = '0;
                if (act_q.rd_len != 16'd0) begin
                  phase_d = PH_RD_START;
                end else if (act_q.wr_len != 16'd0) begin
                  phase_d = PH_WR_DATA;
                end else begin
                  phase_d = PH_WR_STOP;
                end
              end
            end
          end
          PH_WR_DATA: begin
            if (in_q.nack) begin
              phase_d        = PH_IDLE;
              busy_d         = 1'b0;
              rsp_d.action   = ACT_STOP;
              rsp_d.done_res = 1'b1;
              rsp_d.done_tag = act_q.tag;
            end else if (idx_q >= act_q.wr_len) begin
              rsp_d.action = ACT_STOP;
              phase_d      = PH_DONE;
            end else begin
              rsp_d.action       = ACT_SEND_DATA;
              rsp_d.buffer_index = idx_q;
              idx_d              = idx_inc;
              if (idx_inc >= act_q.wr_len) begin
                phase_d = (act_q.rd_len == 16'd0) ? PH_WR_STOP : PH_RD_START;
              end
            end
          end
          PH_WR_STOP, PH_RD_STOP: begin
            rsp_d.action = ACT_STOP;
            phase_d      = PH_DONE;
          end
          PH_DONE: begin
            busy_d         = 1'b0;
            phase_d        = PH_IDLE;
            rsp_d.done_res = 1'b1;
            rsp_d.success  = 1'b1;
            rsp_d.done_tag = act_q.tag;
            if (serve_found && in_q.bus_normal) begin
              do_serve = 1'b1;
            end
          end
          PH_RD_START: begin
            idx_d        = '0;
            rsp_d.action = ACT_RESTART;
            phase_d      = PH_RD_ADDR;
          end
          PH_RD_ADDR: begin
            rsp_d.action    = ACT_SEND_ADDR;
            rsp_d.send_byte = act_q.address | ADDR_RD_BIT;
            phase_d         = PH_RD_ENABLE;
          end
          PH_RD_ENABLE: begin
            if (in_q.nack) begin
              phase_d        = PH_IDLE;
              busy_d         = 1'b0;
              rsp_d.action   = ACT_STOP;
              rsp_d.done_res = 1'b1;
              rsp_d.done_tag = act_q.tag;
            end else begin
              rsp_d.action = ACT_RECEIVE;
              phase_d      = PH_RD_STORE;
            end
          end
          PH_RD_REENABLE: begin
            rsp_d.action = ACT_RECEIVE;
            phase_d      = PH_RD_STORE;
          end
          PH_RD_STORE: begin
            rsp_d.buffer_index = idx_q;
            rsp_d.store_byte   = 1'b1;
            rsp_d.stored_value = in_q.received_byte;
            idx_d              = idx_inc;
            if (idx_inc >= act_q.rd_len) begin
              rsp_d.action = ACT_NACK;
              phase_d      = PH_RD_STOP;
            end else begin
              rsp_d.action = ACT_ACK;
              phase_d      = PH_RD_REENABLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    endcase

    // Start the lowest queued request on the bus.
    if (do_serve) begin
      pend_d[serve_sel] = 1'b0;
      act_d.tag         = wr_slot && (serve_sel == free_sel) ? new_slot.tag
                                                             : slot_q[serve_sel].tag;
      act_d.cmd_len     = wr_slot && (serve_sel == free_sel) ? new_slot.cmd_len
                                                             : slot_q[serve_sel].cmd_len;
      act_d.address     = wr_slot && (serve_sel == free_sel) ? new_slot.address
                                                             : slot_q[serve_sel].address;
      if (wr_slot && (serve_sel == free_sel) ? new_slot.is_read
                                             : slot_q[serve_sel].is_read) begin
        act_d.wr_len = '0;
        act_d.rd_len = wr_slot && (serve_sel == free_sel) ? new_slot.size
                                                          : slot_q[serve_sel].size;
      end else begin
        act_d.wr_len = wr_slot && (serve_sel == free_sel) ? new_slot.size
                                                          : slot_q[serve_sel].size;
        act_d.rd_len = '0;
      end
      busy_d       = 1'b1;
      idx_d        = '0;
      phase_d      = PH_SEND_ADDR;
      rsp_d.action = ACT_START;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      act_q   <= '0;
      pend_q  <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      act_q   <= act_d;
      pend_q  <= pend_d;
    end
  end

  // Slot fields; only a pending slot is ever read.
  always_ff @(posedge clk_i) begin
    if (proc && wr_slot) begin
      slot_q[free_sel] <= new_slot;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (proc) begin
      out_vq <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = out_vq;
  assign rsp_o.action       = out_q.action;
  assign rsp_o.send_byte    = out_q.send_byte;
  assign rsp_o.buffer_index = out_q.buffer_index;
  assign rsp_o.store_byte   = out_q.store_byte;
  assign rsp_o.stored_value = out_q.stored_value;
  assign rsp_o.accepted     = out_q.accepted;
  assign rsp_o.done_res     = out_q.done_res;
  assign rsp_o.success      = out_q.success;
  assign rsp_o.done_tag     = out_q.done_tag;

endmodule
`default_nettype wire
